[rtl/cpc_pkg.sv]
`default_nettype none

package cpc_pkg;

  localparam int NUM_CMDS = 4;
  localparam int CMD_W    = 2;
  localparam int CNT_W    = 3;
  localparam int LEN_W    = 7;
  localparam int POS_W    = 6;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] END_MARKER_RESET = 8'd42;

  localparam logic MODE_RX   = 1'b0;
  localparam logic MODE_TAKE = 1'b1;

  localparam logic [CMD_W-1:0] CMD_LED  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CFG  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIME = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CTR  = 2'd3;

  // Prefix characters, element 0 is the first character of the prefix.
  localparam logic [5:0][BYTE_W-1:0] PREFIX_LED  = {8'h00, ",", "D", "E", "L", "#"};
  localparam logic [5:0][BYTE_W-1:0] PREFIX_CFG  = {8'h00, ",", "G", "F", "C", "#"};
  localparam logic [5:0][BYTE_W-1:0] PREFIX_TIME = {",", "E", "M", "I", "T", "#"};
  localparam logic [5:0][BYTE_W-1:0] PREFIX_CTR  = {8'h00, ",", "R", "T", "C", "#"};

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic                 payload_valid;
    logic [CMD_W-1:0]     cmd_index;
    logic [BYTE_W-1:0]    payload_byte;
    logic [POS_W-1:0]     payload_pos;
    logic                 message_done;
    logic                 message_dropped;
    logic                 taken_valid;
    logic [CMD_W-1:0]     taken_index;
    logic [NUM_CMDS-1:0]  pending_flags;
  } out_item_t;

  function automatic logic [CNT_W-1:0] prefix_len(input logic [CMD_W-1:0] cmd);
    logic [CNT_W-1:0] len;
    case (cmd)
      CMD_TIME: len = 3'd6;
      default:  len = 3'd5;
    endcase
    return len;
  endfunction

  function automatic logic [BYTE_W-1:0] prefix_char(input logic [CMD_W-1:0] cmd,
                                                    input logic [CNT_W-1:0] n);
    logic [5:0][BYTE_W-1:0] row;
    logic [BYTE_W-1:0]      ch;
    case (cmd)
      CMD_LED:  row = PREFIX_LED;
      CMD_CFG:  row = PREFIX_CFG;
      CMD_TIME: row = PREFIX_TIME;
      CMD_CTR:  row = PREFIX_CTR;
      default:  row = PREFIX_LED;
    endcase
    case (n)
      3'd0:    ch = row[0];
      3'd1:    ch = row[1];
      3'd2:    ch = row[2];
      3'd3:    ch = row[3];
      3'd4:    ch = row[4];
      3'd5:    ch = row[5];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

[rtl/command_prefix_payload_capture_unit.sv]
// The result of an accepted input transaction appears on out_* in the next cycle.
// Throughput: one transaction per cycle; the only limit is the single output
// register, which holds the input off only while a result waits under out_stall.
// Reset (rst_n low, synchronous): no capture, all match counters and pending
// flags clear, end marker returns to 42 ('*'), output register empty.
`default_nettype none

module command_prefix_payload_capture_unit #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input channel: a received byte or a take request.
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire cpc_pkg::in_item_t         in_data,
  // Result channel: exactly one result per input transaction.
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output cpc_pkg::out_item_t             out_data,
  // Configuration: end marker byte.
  input  wire logic                      cfg_wr_en,
  input  wire logic [cpc_pkg::BYTE_W-1:0] cfg_wr_data
);

  localparam int NC = cpc_pkg::NUM_CMDS;

  // The payload length counter is seven bits wide, so the limit must fit there.
  localparam logic [cpc_pkg::LEN_W-1:0] LEN_LIMIT = cpc_pkg::LEN_W'(MAX_PAYLOAD);

  // Architectural state of the recognizer.
  logic                              capturing_r, capturing_nxt;
  logic [cpc_pkg::CNT_W-1:0]         cnt_r   [NC];
  logic [cpc_pkg::CNT_W-1:0]         cnt_nxt [NC];
  logic [cpc_pkg::CMD_W-1:0]         active_r, active_nxt;
  logic [cpc_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic [NC-1:0]                     pending_r, pending_nxt;
  logic [cpc_pkg::BYTE_W-1:0]        end_marker_r;

  // Output register.
  logic                              out_valid_r;
  cpc_pkg::out_item_t                out_data_r;
  cpc_pkg::out_item_t                res;

  logic                              in_accept;
  logic [cpc_pkg::LEN_W-1:0]         len_inc;

  // The output register can take a new result when it is empty or is being
  // drained in this same cycle; while so, a new transaction enters every cycle.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign len_inc = len_r + cpc_pkg::LEN_W'(1);

  always_comb begin
    logic end_now;
    logic [cpc_pkg::CNT_W-1:0] n;

    capturing_nxt = capturing_r;
    active_nxt    = active_r;
    len_nxt       = len_r;
    pending_nxt   = pending_r;
    for (int i = 0; i < NC; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    end_now = 1'b0;
    n       = '0;
    res     = '0;

    if (in_data.mode == cpc_pkg::MODE_TAKE) begin
      // Clear the lowest-numbered pending flag. The scan runs from the top,
      // so the last hit is the winner.
      for (int i = NC - 1; i >= 0; i--) begin
        if (pending_r[i]) begin
          res.taken_valid = 1'b1;
          res.taken_index = cpc_pkg::CMD_W'(i);
        end
      end
      if (res.taken_valid) begin
        pending_nxt[res.taken_index] = 1'b0;
      end
    end else if (!capturing_r) begin
      // All four prefixes are tracked side by side. A mismatching byte only
      // clears the counter; it is not retried as a first character. When two
      // prefixes complete on one byte the higher index is taken last and wins.
      for (int i = 0; i < NC; i++) begin
        n = cnt_r[i];
        if (n < cpc_pkg::prefix_len(cpc_pkg::CMD_W'(i)) &&
            in_data.rx_byte == cpc_pkg::prefix_char(cpc_pkg::CMD_W'(i), n)) begin
          cnt_nxt[i] = n + cpc_pkg::CNT_W'(1);
          if (cnt_nxt[i] == cpc_pkg::prefix_len(cpc_pkg::CMD_W'(i))) begin
            active_nxt    = cpc_pkg::CMD_W'(i);
            capturing_nxt = 1'b1;
            len_nxt       = '0;
          end
        end else begin
          cnt_nxt[i] = '0;
        end
      end
    end else begin
      // Capturing a payload for the active command.
      res.cmd_index = active_r;
      if (pending_r[active_r]) begin
        // The previous message of this command has not been taken yet.
        res.message_dropped = 1'b1;
        end_now             = 1'b1;
      end else if (in_data.rx_byte == end_marker_r) begin
        pending_nxt[active_r] = 1'b1;
        res.message_done      = 1'b1;
        end_now               = 1'b1;
      end else begin
        res.payload_valid = 1'b1;
        res.payload_byte  = in_data.rx_byte;
        res.payload_pos   = len_r[cpc_pkg::POS_W-1:0];
      end
      len_nxt = len_inc;
      // The byte at the last allowed position is still emitted; the message
      // is then dropped unless that byte already closed it.
      if (len_inc >= LEN_LIMIT) begin
        if (!end_now) begin
          res.message_dropped = 1'b1;
        end
        end_now = 1'b1;
      end
      if (end_now) begin
        capturing_nxt = 1'b0;
        for (int i = 0; i < NC; i++) begin
          cnt_nxt[i] = '0;
        end
      end
    end

    res.pending_flags = pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r  <= 1'b0;
      active_r     <= '0;
      len_r        <= '0;
      pending_r    <= '0;
      end_marker_r <= cpc_pkg::END_MARKER_RESET;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NC; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        end_marker_r <= cfg_wr_data;
      end
      if (in_accept) begin
        capturing_r <= capturing_nxt;
        active_r    <= active_nxt;
        len_r       <= len_nxt;
        pending_r   <= pending_nxt;
        for (int i = 0; i < NC; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/cpc_checker.sv]
`default_nettype none

module cpc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire cpc_pkg::out_item_t out_data
);

  // Every accepted transaction produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // A stalled result holds.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // A waiting result blocks the input side.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input accepted while result is stalled");

  // A result carries at most one kind of event. The byte at the length limit
  // is both emitted and dropped, so those two count as one.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_data.payload_valid || out_data.message_dropped,
                               out_data.message_done, out_data.taken_valid}) <= 1))
    else $error("result carries more than one event");

  // A take clears the flag it reports.
  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.taken_valid) |-> !out_data.pending_flags[out_data.taken_index])
    else $error("taken flag still pending");

endmodule

bind command_prefix_payload_capture_unit cpc_checker u_cpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[test/cpc_result_checker.sv]
module cpc_result_checker
  import cpc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [BYTE_W-1:0] cfg_wr_data,
  output int                fail_count,
  output int                results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Prefix rows and lengths, indexed by command number.
  localparam logic [NUM_CMDS-1:0][5:0][BYTE_W-1:0] PREFIX_ROWS =
    {PREFIX_CTR, PREFIX_TIME, PREFIX_CFG, PREFIX_LED};
  localparam logic [NUM_CMDS-1:0][CNT_W-1:0] PREFIX_LENS = {3'd5, 3'd6, 3'd5, 3'd5};

  logic [BYTE_W-1:0]               end_marker;
  logic                            capturing;
  logic [NUM_CMDS-1:0][CNT_W-1:0]  match_count;
  logic [CMD_W-1:0]                active_cmd;
  logic [LEN_W-1:0]                payload_len;
  logic [NUM_CMDS-1:0]             pending;
  out_item_t                       capture_results_due[$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  task automatic report_mismatch(input string text);
    $display("[%0t] MISMATCH: %s", $realtime, text);
    fail_count++;
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%h, expected 0x%h", field, got, want));
    end
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    check_field("payload_valid", got.payload_valid, want.payload_valid);
    check_field("cmd_index", got.cmd_index, want.cmd_index);
    check_field("payload_byte", got.payload_byte, want.payload_byte);
    check_field("payload_pos", got.payload_pos, want.payload_pos);
    check_field("message_done", got.message_done, want.message_done);
    check_field("message_dropped", got.message_dropped, want.message_dropped);
    check_field("taken_valid", got.taken_valid, want.taken_valid);
    check_field("taken_index", got.taken_index, want.taken_index);
    check_field("pending_flags", got.pending_flags, want.pending_flags);
  endtask

  // Advances the capture state by one transaction and builds its result.
  task automatic predict_capture_step(input in_item_t item, output out_item_t res);
    logic [CNT_W-1:0] n;
    logic [CMD_W-1:0] cmd;
    logic             end_now;
    res     = '0;
    end_now = 1'b0;
    if (item.mode == MODE_TAKE) begin
      for (int i = 0; i < NUM_CMDS; i++) begin
        if (pending[i] && !res.taken_valid) begin
          pending[i]      = 1'b0;
          res.taken_valid = 1'b1;
          res.taken_index = i[CMD_W-1:0];
        end
      end
    end else if (!capturing) begin
      // All four prefixes are tracked in parallel; a mismatching byte only
      // clears the counter and is not tried again as a first character.
      for (int i = 0; i < NUM_CMDS; i++) begin
        n = match_count[i];
        if (n < PREFIX_LENS[i] && item.rx_byte == PREFIX_ROWS[i][n]) begin
          n = n + 3'd1;
          match_count[i] = n;
          if (n == PREFIX_LENS[i]) begin
            active_cmd  = i[CMD_W-1:0];
            capturing   = 1'b1;
            payload_len = '0;
          end
        end else begin
          match_count[i] = '0;
        end
      end
    end else begin
      cmd           = active_cmd;
      res.cmd_index = cmd;
      if (pending[cmd]) begin
        res.message_dropped = 1'b1;
        end_now             = 1'b1;
      end else if (item.rx_byte == end_marker) begin
        pending[cmd]     = 1'b1;
        res.message_done = 1'b1;
        end_now          = 1'b1;
      end else begin
        res.payload_valid = 1'b1;
        res.payload_byte  = item.rx_byte;
        res.payload_pos   = payload_len[POS_W-1:0];
      end
      payload_len = payload_len + 7'd1;
      if (payload_len >= MAX_PAYLOAD) begin
        if (!end_now) begin
          res.message_dropped = 1'b1;
        end
        end_now = 1'b1;
      end
      if (end_now) begin
        capturing   = 1'b0;
        match_count = '0;
      end
    end
    res.pending_flags = pending;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      end_marker  = END_MARKER_RESET;
      capturing   = 1'b0;
      match_count = '0;
      active_cmd  = CMD_LED;
      payload_len = '0;
      pending     = '0;
      capture_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (capture_results_due.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = capture_results_due.pop_front();
          check_result(out_data, want);
        end
      end
      if (in_valid && !in_stall) begin
        predict_capture_step(in_data, want);
        capture_results_due.push_back(want);
      end
      if (cfg_wr_en) begin
        end_marker = cfg_wr_data;
      end
    end
    results_owed <= capture_results_due.size();
  end

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpc_pkg::*;

  localparam int PAYLOAD_LIMIT = 64;
  // Cycles without any accepted transaction before the run is declared hung.
  // The longest legitimate quiet stretch is a long sender gap plus a long
  // receiver stall plus a short drain.
  localparam int QUIET_LIMIT   = 2000;
  // Random transactions per configuration phase, after the long message.
  localparam int PHASE_ITEMS   = 40;
  localparam int NUM_PHASES    = 5;
  localparam logic [BYTE_W-1:0] HASH_CHAR  = "#";
  localparam logic [BYTE_W-1:0] COMMA_CHAR = ",";

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  in_item_t          in_data     = '0;
  logic              out_stall   = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [BYTE_W-1:0] cfg_wr_data = END_MARKER_RESET;
  logic              in_stall;
  logic              out_valid;
  out_item_t         out_data;
  int                fail_count;
  int                results_owed;

  // The end marker the block currently holds, mirrored so that payload bytes
  // can avoid it and well-formed messages can close with it.
  logic [BYTE_W-1:0] marker       = END_MARKER_RESET;
  // When set, neither side idles: back-to-back transactions at full rate.
  bit                steady       = 1'b0;
  int                items_sent   = 0;
  int                stall_left   = 0;
  int                quiet_cycles = 0;

  command_prefix_payload_capture_unit #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  cpc_result_checker #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle stretches for either side, with a long one now and then so that
  // gaps land on every phase of a capture.
  function automatic int idle_length();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(40, 10);
    end
    return $urandom_range(3, 1);
  endfunction

  function automatic string prefix_text(input logic [CMD_W-1:0] cmd);
    string s;
    case (cmd)
      CMD_LED:  s = "#LED,";
      CMD_CFG:  s = "#CFG,";
      CMD_TIME: s = "#TIME,";
      default:  s = "#CTR,";
    endcase
    return s;
  endfunction

  // A random payload byte that is never the current end marker, so that a
  // message only closes where the stimulus means it to.
  function automatic logic [BYTE_W-1:0] payload_char();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(255));
    if (b == marker) begin
      b = ~b;
    end
    return b;
  endfunction

  // The receiver stalls at random. A stall, once started, runs its full
  // length, and during steady phases the result side never pushes back.
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < 25) begin
      out_stall <= 1'b1;
      stall_left = idle_length() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: any accepted transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("command_prefix_payload_capture_unit verification failed");
      $finish;
    end
  end

  // Presents one input transaction and holds it until the block takes it.
  // Valid stays high into the next transaction unless a gap is chosen, so it
  // is never dropped and raised again within one time step.
  task automatic send_item(input logic mode, input logic [BYTE_W-1:0] b);
    in_data  <= in_item_t'{mode: mode, rx_byte: b};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat (idle_length()) @(posedge clk);
    end
  endtask

  task automatic send_take();
    send_item(MODE_TAKE, BYTE_W'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(MODE_RX, s[i]);
    end
  endtask

  // A complete command: prefix, payload of the given length, and the end
  // marker if the message is to be closed.
  task automatic send_message(input logic [CMD_W-1:0] cmd, input int len,
                              input bit closed);
    send_text(prefix_text(cmd));
    repeat (len) send_item(MODE_RX, payload_char());
    if (closed) begin
      send_item(MODE_RX, marker);
    end
  endtask

  // Stops sending and waits for every outstanding result. The first clock
  // edge lets the checker's count include a transaction accepted just now.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (3) @(posedge clk);
  endtask

  // The register is only written with the block drained and quiet.
  task automatic write_marker(input logic [BYTE_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    marker = value;
  endtask

  initial begin : stimulus
    int                pick;
    int                cut;
    int                start_count;
    int                long_len;
    bit                long_closed;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] next_marker;
    string             txt;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the end marker at its reset value.
    // A full LED message carrying the byte extremes, which leaves LED pending.
    send_text("#LED,");
    send_item(MODE_RX, 8'h00);
    send_item(MODE_RX, 8'hFF);
    send_item(MODE_RX, marker);
    // LED is still pending, so the first payload byte aborts the capture.
    send_text("#LED,");
    send_item(MODE_RX, 8'h5A);
    // The second hash is a mismatch and is not retried as a first character,
    // so this must not start a capture.
    send_text("##LED,");
    // A take in the middle of a capture clears LED without disturbing it.
    send_text("#CTR,");
    send_item(MODE_TAKE, 8'hFF);
    send_item(MODE_RX, marker);
    // Clears CTR, then a take with nothing pending.
    send_item(MODE_TAKE, 8'h00);
    send_item(MODE_TAKE, 8'hA5);
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       next_marker = 8'h00;
        1:       next_marker = 8'hFF;
        2:       next_marker = BYTE_W'($urandom_range(255));
        3:       next_marker = COMMA_CHAR;
        default: next_marker = END_MARKER_RESET;
      endcase
      write_marker(next_marker);
      steady = (phase == 2);

      // Each phase opens with one message near the length limit: the end
      // marker on the last allowed position, a payload that runs into the
      // limit, one just short of it, and one that overruns it by several bytes.
      case (phase)
        0:       begin long_len = 63; long_closed = 1'b1; end
        1:       begin long_len = 64; long_closed = 1'b0; end
        2:       begin long_len = 62; long_closed = 1'b1; end
        3:       begin long_len = 70; long_closed = 1'b0; end
        default: begin long_len = 64; long_closed = 1'b1; end
      endcase
      repeat (NUM_CMDS) send_take();
      send_message(CMD_W'($urandom_range(3)), long_len, long_closed);

      start_count = items_sent;
      while (items_sent - start_count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // Well-formed messages with random command and content, mostly
          // short, sometimes left open.
          send_message(CMD_W'($urandom_range(3)),
                       ($urandom_range(9) == 0) ? $urandom_range(40, 9)
                                                : $urandom_range(8, 0),
                       $urandom_range(9) != 0);
        end else if (pick < 75) begin
          send_take();
        end else if (pick < 88) begin
          // A prefix cut short and followed by an arbitrary byte.
          cmd = CMD_W'($urandom_range(3));
          txt = prefix_text(cmd);
          cut = $urandom_range(txt.len() - 1, 1);
          for (int i = 0; i < cut; i++) begin
            send_item(MODE_RX, txt[i]);
          end
          send_item(MODE_RX, BYTE_W'($urandom_range(255)));
        end else if (pick < 97) begin
          // Line noise, with extra hash characters to stir the matchers.
          repeat ($urandom_range(4, 1)) begin
            send_item(MODE_RX, ($urandom_range(3) == 0) ? HASH_CHAR
                                                         : BYTE_W'($urandom_range(255)));
          end
        end else begin
          // Hold off until every result is back, then carry on.
          wait_drained();
        end
      end
      wait_drained();
    end

    steady = 1'b0;
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("command_prefix_payload_capture_unit verification clean");
    end else begin
      $display("command_prefix_payload_capture_unit verification failed");
    end
    $finish;
  end

endmodule
